// ===== hdl/mbrs_pkg.sv =====
// Shared constants, codes and the CRC step for the Modbus RTU slave engine.
`timescale 1ns / 1ps
package mbrs_pkg;
   localparam int REG_COUNT_DEF = 64;
   localparam int RX_DEPTH_DEF  = 260;
   localparam int TX_DEPTH_DEF  = 255;

   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_TIMEOUT = 2'd1;
   localparam logic [1:0] ACT_HOST_WR = 2'd2;
   localparam logic [1:0] ACT_HOST_RD = 2'd3;

   localparam logic [3:0] ST_STORED    = 4'd0;
   localparam logic [3:0] ST_IGNORED   = 4'd1;
   localparam logic [3:0] ST_OTHER     = 4'd2;
   localparam logic [3:0] ST_TOO_LONG  = 4'd3;
   localparam logic [3:0] ST_TOO_SHORT = 4'd4;
   localparam logic [3:0] ST_BAD_CRC   = 4'd5;
   localparam logic [3:0] ST_RESPONSE  = 4'd6;
   localparam logic [3:0] ST_EXC_FUNC  = 4'd7;
   localparam logic [3:0] ST_EXC_ADDR  = 4'd8;
   localparam logic [3:0] ST_EXC_DEV   = 4'd9;
   localparam logic [3:0] ST_IDLE      = 4'd10;
   localparam logic [3:0] ST_HOST      = 4'd11;

   localparam logic [7:0] FN_RD_HOLD  = 8'h03;
   localparam logic [7:0] FN_RD_INPUT = 8'h04;
   localparam logic [7:0] FN_WR_ONE   = 8'h06;
   localparam logic [7:0] FN_WR_MANY  = 8'h10;
   localparam logic [7:0] FN_EXC_FLAG = 8'h80;

   localparam logic [7:0] EXC_FUNC = 8'h01;
   localparam logic [7:0] EXC_ADDR = 8'h02;
   localparam logic [7:0] EXC_DEV  = 8'h04;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
      logic [15:0] c;
      c = c_in ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction
endpackage

// ===== hdl/mbrs_req_if.sv =====
// Request channel of the Modbus RTU slave engine.
`timescale 1ns / 1ps
interface mbrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  rx_byte;
   logic [15:0] host_addr;
   logic [15:0] host_data;
   modport source (output valid, action, rx_byte, host_addr, host_data, input ready);
   modport sink (input valid, action, rx_byte, host_addr, host_data, output ready);
endinterface

// ===== hdl/mbrs_rsp_if.sv =====
// Response channel of the Modbus RTU slave engine.
`timescale 1ns / 1ps
interface mbrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] tx_data;
   logic [2:0]  tx_count;
   logic        tx_last;
   logic [3:0]  status;
   logic [15:0] host_read_data;
   modport source (output valid, tx_data, tx_count, tx_last, status, host_read_data,
                   input ready);
   modport sink (input valid, tx_data, tx_count, tx_last, status, host_read_data,
                 output ready);
endinterface

// ===== hdl/modbus_rtu_slave_engine.sv =====
// Modbus RTU slave: frames received bytes for its station address into a receive
// memory, and on a silence timeout checks the frame and serves functions 3, 4, 6 and 16
// on a 16-bit register memory that the host may also read and write. A timeout on a
// collected frame sweeps the receive memory at one byte a cycle, then sends the response
// one byte a cycle while the response side accepts it, up to four bytes to a result;
// function 16 then writes each register by reading its two bytes through the single read
// port of the receive memory and then writing the register. No clearing pass is needed
// after reset.
`timescale 1ns / 1ps
module modbus_rtu_slave_engine
   import mbrs_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEF,
   parameter int RX_DEPTH  = RX_DEPTH_DEF,
   parameter int TX_DEPTH  = TX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mbrs_req_if.sink    req_chan,
   mbrs_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   localparam int RI_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int LEN_W = $clog2(RX_DEPTH + 1);
   localparam int TJ_W  = $clog2(TX_DEPTH + 1);
   localparam logic [16:0]      REG_LIM = 17'(REG_COUNT);
   localparam logic [17:0]      TX_LIM  = 18'(TX_DEPTH);
   localparam logic [LEN_W-1:0] RX_LIM  = LEN_W'(RX_DEPTH);

   typedef enum logic [1:0] {MODE_WAIT, MODE_SKIP, MODE_RECV} mode_type;
   typedef enum logic [1:0] {K_EXC, K_READ, K_WRITE} kind_type;
   typedef enum logic [2:0] {S_IDLE, S_HREAD, S_SCAN, S_CHECK, S_EMIT, S_WHI, S_WLO, S_WWR}
      state_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   kind_type         kind_ff, kind_in;
   logic [7:0]       slave_ff;
   logic [LEN_W-1:0] rxlen_ff, rxlen_in, flen_ff, flen_in;
   logic [LEN_W-1:0] sc_ff, sc_in, dpos_ff, dpos_in;
   logic             dv_ff, dv_in, hok_ff, hok_in, hv_ff, hv_in;
   logic [15:0]      crc_ff, crc_in, rc_ff, rc_in;
   logic [7:0]       fn_ff, fn_in, hdr1_ff, hdr1_in, hdr2_ff, hdr2_in, whi_ff, whi_in;
   logic [15:0]      addr_ff, addr_in, cnt_ff, cnt_in, widx_ff, widx_in;
   logic [TJ_W-1:0]  elen_ff, elen_in, j_ff, j_in;
   logic [3:0]       est_ff, est_in;
   logic [31:0]      word_ff, word_in;
   logic [1:0]       bcnt_ff, bcnt_in;
   logic [RI_W-1:0]  radr_ff, radr_in;

   logic             ov_ff;
   logic [31:0]      odata_ff;
   logic [2:0]       ocnt_ff;
   logic             olast_ff;
   logic [3:0]       ost_ff;
   logic [15:0]      ohrd_ff;

   logic             push, push_last;
   logic [31:0]      push_data;
   logic [2:0]       push_cnt;
   logic [3:0]       push_st;
   logic [15:0]      push_hrd;

   logic [7:0]       rx_mem [RX_DEPTH];
   logic [7:0]       rx_q_ff;
   logic             rx_we, rx_re;
   logic [RX_AW-1:0] rx_wa, rx_ra;
   logic [7:0]       rx_wd;

   logic [15:0]      rf_mem [REG_COUNT];
   logic             rf_vld_ff [REG_COUNT];
   logic [15:0]      rf_q_ff;
   logic             rf_vq_ff;
   logic             rf_we, rf_re;
   logic [RI_W-1:0]  rf_wa, rf_ra;
   logic [15:0]      rf_wd, reg_q;

   logic             out_free, acc;
   logic [LEN_W-1:0] eff_len;
   logic [16:0]      sum17, wa17;
   logic [17:0]      dbl18, idx18;
   logic [7:0]       eb;
   logic [31:0]      wnew;
   logic             last_byte, need_push;

   assign out_free = !ov_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign acc = req_chan.valid && req_chan.ready;
   assign reg_q = rf_vq_ff ? rf_q_ff : 16'h0000;

   assign rsp_chan.valid          = ov_ff;
   assign rsp_chan.tx_data        = odata_ff;
   assign rsp_chan.tx_count       = ocnt_ff;
   assign rsp_chan.tx_last        = olast_ff;
   assign rsp_chan.status         = ost_ff;
   assign rsp_chan.host_read_data = ohrd_ff;

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; kind_in = kind_ff;
      rxlen_in = rxlen_ff; flen_in = flen_ff; sc_in = sc_ff; dpos_in = dpos_ff;
      dv_in = dv_ff; hok_in = hok_ff; hv_in = hv_ff;
      crc_in = crc_ff; rc_in = rc_ff; fn_in = fn_ff; hdr1_in = hdr1_ff; hdr2_in = hdr2_ff;
      whi_in = whi_ff; addr_in = addr_ff; cnt_in = cnt_ff; widx_in = widx_ff;
      elen_in = elen_ff; j_in = j_ff; est_in = est_ff; word_in = word_ff;
      bcnt_in = bcnt_ff; radr_in = radr_ff;
      push = 1'b0; push_data = 32'h0; push_cnt = 3'd0; push_last = 1'b1;
      push_st = ST_IDLE; push_hrd = 16'h0;
      rx_we = 1'b0; rx_wa = '0; rx_wd = 8'h00; rx_re = 1'b0; rx_ra = '0;
      rf_we = 1'b0; rf_wa = '0; rf_wd = 16'h0; rf_re = 1'b0; rf_ra = '0;
      eff_len = '0; sum17 = '0; wa17 = '0; dbl18 = '0; idx18 = '0;
      eb = 8'h00; wnew = 32'h0; last_byte = 1'b0; need_push = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (req_chan.action)
                  ACT_BYTE: begin
                     eff_len = (mode_ff == MODE_WAIT) ? '0 : rxlen_ff;
                     push = 1'b1;
                     if (mode_ff == MODE_WAIT && req_chan.rx_byte != slave_ff) begin
                        mode_in = MODE_SKIP;
                        push_st = ST_OTHER;
                     end else if (mode_ff == MODE_SKIP) begin
                        push_st = ST_IGNORED;
                     end else if (eff_len < RX_LIM) begin
                        rx_we    = 1'b1;
                        rx_wa    = eff_len[RX_AW-1:0];
                        rx_wd    = req_chan.rx_byte;
                        rxlen_in = eff_len + LEN_W'(1);
                        mode_in  = MODE_RECV;
                        push_st  = ST_STORED;
                     end else begin
                        mode_in = MODE_SKIP;
                        push_st = ST_TOO_LONG;
                     end
                  end
                  ACT_TIMEOUT: begin
                     if (mode_ff != MODE_RECV || rxlen_ff < LEN_W'(3)) begin
                        mode_in  = MODE_WAIT;
                        rxlen_in = '0;
                        push     = 1'b1;
                        push_st  = (mode_ff != MODE_RECV) ? ST_IDLE : ST_TOO_SHORT;
                     end else begin
                        flen_in  = rxlen_ff;
                        sc_in    = '0;
                        dv_in    = 1'b0;
                        crc_in   = CRC_INIT;
                        fn_in    = 8'h00;
                        addr_in  = 16'h0;
                        cnt_in   = 16'h0;
                        state_in = S_SCAN;
                     end
                  end
                  ACT_HOST_WR: begin
                     if ({1'b0, req_chan.host_addr} < REG_LIM) begin
                        rf_we = 1'b1;
                        rf_wa = req_chan.host_addr[RI_W-1:0];
                        rf_wd = req_chan.host_data;
                     end
                     push    = 1'b1;
                     push_st = ST_HOST;
                  end
                  default: begin
                     rf_re    = 1'b1;
                     rf_ra    = req_chan.host_addr[RI_W-1:0];
                     hok_in   = {1'b0, req_chan.host_addr} < REG_LIM;
                     state_in = S_HREAD;
                  end
               endcase
            end
         end
         S_HREAD: begin
            push     = 1'b1;
            push_st  = ST_HOST;
            push_hrd = hok_ff ? reg_q : 16'h0;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // Issue the next read while the previous byte is folded in.
            if (sc_ff < flen_ff) begin
               rx_re   = 1'b1;
               rx_ra   = sc_ff[RX_AW-1:0];
               sc_in   = sc_ff + LEN_W'(1);
               dpos_in = sc_ff;
               dv_in   = 1'b1;
            end else begin
               dv_in = 1'b0;
            end
            if (dv_ff) begin
               if (dpos_ff < flen_ff - LEN_W'(2)) crc_in = crc_byte(crc_ff, rx_q_ff);
               if (dpos_ff == LEN_W'(1)) fn_in = rx_q_ff;
               if (dpos_ff == LEN_W'(2)) addr_in[15:8] = rx_q_ff;
               if (dpos_ff == LEN_W'(3)) addr_in[7:0] = rx_q_ff;
               if (dpos_ff == LEN_W'(4)) cnt_in[15:8] = rx_q_ff;
               if (dpos_ff == LEN_W'(5)) cnt_in[7:0] = rx_q_ff;
               if (dpos_ff == flen_ff - LEN_W'(2)) rc_in[7:0] = rx_q_ff;
               if (dpos_ff == flen_ff - LEN_W'(1)) begin
                  rc_in[15:8] = rx_q_ff;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            mode_in  = MODE_WAIT;
            rxlen_in = '0;
            j_in     = '0;
            bcnt_in  = 2'd0;
            word_in  = 32'h0;
            crc_in   = CRC_INIT;
            radr_in  = addr_ff[RI_W-1:0];
            widx_in  = 16'h0;
            sum17    = {1'b0, addr_ff} + {1'b0, cnt_ff};
            dbl18    = {1'b0, cnt_ff, 1'b0} + 18'd5;
            kind_in  = K_EXC;
            hdr1_in  = fn_ff | FN_EXC_FLAG;
            elen_in  = TJ_W'(3);
            state_in = S_EMIT;
            if (crc_ff != rc_ff) begin
               // Hold the computed CRC while the status result waits.
               crc_in   = crc_ff;
               state_in = S_CHECK;
               if (out_free) begin
                  push     = 1'b1;
                  push_st  = ST_BAD_CRC;
                  state_in = S_IDLE;
               end
            end else if (fn_ff == FN_RD_HOLD || fn_ff == FN_RD_INPUT) begin
               if (sum17 > REG_LIM) begin
                  hdr2_in = EXC_ADDR;
                  est_in  = ST_EXC_ADDR;
               end else if (dbl18 > TX_LIM) begin
                  hdr2_in = EXC_DEV;
                  est_in  = ST_EXC_DEV;
               end else begin
                  kind_in = K_READ;
                  hdr1_in = fn_ff;
                  hdr2_in = {cnt_ff[6:0], 1'b0};
                  elen_in = TJ_W'(dbl18 - 18'd2);
                  est_in  = ST_RESPONSE;
               end
            end else if (fn_ff == FN_WR_ONE || fn_ff == FN_WR_MANY) begin
               if ({1'b0, addr_ff} > REG_LIM) begin
                  hdr2_in = EXC_ADDR;
                  est_in  = ST_EXC_ADDR;
               end else begin
                  kind_in = K_WRITE;
                  hdr1_in = fn_ff;
                  hdr2_in = addr_ff[15:8];
                  elen_in = TJ_W'(6);
                  est_in  = ST_RESPONSE;
                  if (fn_ff == FN_WR_ONE && {1'b0, addr_ff} < REG_LIM) begin
                     rf_we = 1'b1;
                     rf_wa = addr_ff[RI_W-1:0];
                     rf_wd = cnt_ff;
                  end
               end
            end else begin
               hdr2_in = EXC_FUNC;
               est_in  = ST_EXC_FUNC;
            end
         end
         S_EMIT: begin
            if (j_ff < elen_ff) begin
               if (j_ff == TJ_W'(0)) eb = slave_ff;
               else if (j_ff == TJ_W'(1)) eb = hdr1_ff;
               else if (j_ff == TJ_W'(2)) eb = hdr2_ff;
               else if (kind_ff == K_WRITE) begin
                  if (j_ff == TJ_W'(3)) eb = addr_ff[7:0];
                  else if (j_ff == TJ_W'(4)) eb = cnt_ff[15:8];
                  else eb = cnt_ff[7:0];
               end else begin
                  eb = j_ff[0] ? reg_q[15:8] : reg_q[7:0];
               end
            end else if (j_ff == elen_ff) begin
               eb = crc_ff[7:0];
            end else begin
               eb = crc_ff[15:8];
            end
            last_byte = (j_ff == elen_ff + TJ_W'(1));
            need_push = last_byte || (bcnt_ff == 2'd3);
            wnew      = word_ff | (32'(eb) << {bcnt_ff, 3'b000});
            if (!need_push || out_free) begin
               if (j_ff < elen_ff) crc_in = crc_byte(crc_ff, eb);
               j_in = j_ff + TJ_W'(1);
               // Fetch the register whose high byte goes out next.
               if (kind_ff == K_READ && j_ff >= TJ_W'(2) && !j_ff[0] &&
                   j_ff + TJ_W'(1) < elen_ff) begin
                  rf_re   = 1'b1;
                  rf_ra   = radr_ff;
                  radr_in = radr_ff + RI_W'(1);
               end
               if (need_push) begin
                  push      = 1'b1;
                  push_data = wnew;
                  push_cnt  = {1'b0, bcnt_ff} + 3'd1;
                  push_last = last_byte;
                  push_st   = est_ff;
                  word_in   = 32'h0;
                  bcnt_in   = 2'd0;
               end else begin
                  word_in = wnew;
                  bcnt_in = bcnt_ff + 2'd1;
               end
               if (last_byte) begin
                  state_in = (kind_ff == K_WRITE && fn_ff == FN_WR_MANY) ? S_WHI : S_IDLE;
               end
            end
         end
         S_WHI: begin
            wa17  = {1'b0, addr_ff} + {1'b0, widx_ff};
            idx18 = {1'b0, widx_ff, 1'b0} + 18'd7;
            if (widx_ff < cnt_ff && wa17 < REG_LIM) begin
               hv_in    = idx18 < 18'(flen_ff);
               rx_re    = 1'b1;
               rx_ra    = idx18[RX_AW-1:0];
               state_in = S_WLO;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WLO: begin
            idx18    = {1'b0, widx_ff, 1'b0} + 18'd8;
            whi_in   = hv_ff ? rx_q_ff : 8'h00;
            hv_in    = idx18 < 18'(flen_ff);
            rx_re    = 1'b1;
            rx_ra    = idx18[RX_AW-1:0];
            state_in = S_WWR;
         end
         S_WWR: begin
            wa17     = {1'b0, addr_ff} + {1'b0, widx_ff};
            rf_we    = 1'b1;
            rf_wa    = wa17[RI_W-1:0];
            rf_wd    = {whi_ff, hv_ff ? rx_q_ff : 8'h00};
            widx_in  = widx_ff + 16'd1;
            state_in = S_WHI;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_WAIT;
         rxlen_ff <= '0;
         dv_ff    <= 1'b0;
         ov_ff    <= 1'b0;
         slave_ff <= 8'h00;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         rxlen_ff <= rxlen_in;
         dv_ff    <= dv_in;
         if (csr_wr_en) slave_ff <= csr_wr_data;
         if (push) ov_ff <= 1'b1;
         else if (rsp_chan.ready) ov_ff <= 1'b0;
      end
      kind_ff <= kind_in; flen_ff <= flen_in; sc_ff <= sc_in; dpos_ff <= dpos_in;
      hok_ff <= hok_in; hv_ff <= hv_in; crc_ff <= crc_in; rc_ff <= rc_in;
      fn_ff <= fn_in; hdr1_ff <= hdr1_in; hdr2_ff <= hdr2_in; whi_ff <= whi_in;
      addr_ff <= addr_in; cnt_ff <= cnt_in; widx_ff <= widx_in; elen_ff <= elen_in;
      j_ff <= j_in; est_ff <= est_in; word_ff <= word_in; bcnt_ff <= bcnt_in;
      radr_ff <= radr_in;
      if (push) begin
         odata_ff <= push_data;
         ocnt_ff  <= push_cnt;
         olast_ff <= push_last;
         ost_ff   <= push_st;
         ohrd_ff  <= push_hrd;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_wa] <= rx_wd;
      if (rx_re) rx_q_ff <= rx_mem[rx_ra];
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rf_wa] <= rf_wd;
      if (rf_re) begin
         rf_q_ff  <= rf_mem[rf_ra];
         rf_vq_ff <= rf_vld_ff[rf_ra];
      end
   end

   // Entries never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) rf_vld_ff[i] <= 1'b0;
      end else if (rf_we) begin
         rf_vld_ff[rf_wa] <= 1'b1;
      end
   end

`ifndef ASSERT_OFF
   a_push_free: assert property (@(posedge clock) disable iff (reset) push |-> out_free)
      else $error("result pushed over a waiting result");
   a_len_bound: assert property (@(posedge clock) disable iff (reset) rxlen_ff <= RX_LIM)
      else $error("receive length beyond store depth");
   a_scan_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && dv_ff) |-> dpos_ff < flen_ff)
      else $error("sweep beyond frame length");
   a_tx_status: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && ocnt_ff != 3'd0) |-> (ost_ff == ST_RESPONSE || ost_ff == ST_EXC_FUNC ||
                                       ost_ff == ST_EXC_ADDR || ost_ff == ST_EXC_DEV))
      else $error("bytes carried on a plain status result");
`endif
endmodule

// ===== dv/mbrs_checker.sv =====
// Checker for the Modbus RTU slave engine: predicts every response and compares it.
`timescale 1ns / 1ps
module mbrs_checker
   import mbrs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mbrs_req_if  req,
   mbrs_rsp_if  rsp,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int   fail_count,
   output int   pending,
   output int   frames_served
);
   typedef struct packed {
      logic [31:0] tx_data;
      logic [2:0]  tx_count;
      logic        tx_last;
      logic [3:0]  status;
      logic [15:0] host_read_data;
   } rsp_word_t;

   typedef enum logic [1:0] {RX_WAIT, RX_SKIP, RX_RECV} rx_mode_t;

   rsp_word_t   expected_rsps[$];
   logic [7:0]  station;
   rx_mode_t    mode;
   logic [7:0]  rx_mem[RX_DEPTH_DEF];
   int unsigned rx_len;
   logic [15:0] regs[REG_COUNT_DEF];
   logic [7:0]  tx_buf[TX_DEPTH_DEF + 8];

   function automatic logic [15:0] crc16_of(input bit from_rx, input int unsigned n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int unsigned i = 0; i < n; i++) begin
         c ^= {8'h00, from_rx ? rx_mem[i] : tx_buf[i]};
         for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] rx_at(input int unsigned i);
      return (i < rx_len && i < RX_DEPTH_DEF) ? rx_mem[i] : 8'h00;
   endfunction

   task automatic push_status(input logic [3:0] st, input logic [15:0] hrd);
      expected_rsps.push_back('{32'h0, 3'd0, 1'b1, st, hrd});
   endtask

   // Append the CRC, then cut the frame into four-byte words
   task automatic emit_frame(input int unsigned len, input logic [3:0] st);
      logic [15:0] c;
      int unsigned total, n;
      rsp_word_t w;
      c = crc16_of(1'b0, len);
      tx_buf[len] = c[7:0];
      tx_buf[len + 1] = c[15:8];
      total = len + 2;
      n = (total + 3) / 4;
      for (int unsigned k = 0; k < n; k++) begin
         w = '{32'h0, 3'd0, k + 1 == n, st, 16'h0};
         for (int unsigned i = 0; i < 4 && k * 4 + i < total; i++) begin
            w.tx_data[8 * i +: 8] = tx_buf[k * 4 + i];
            w.tx_count++;
         end
         expected_rsps.push_back(w);
      end
   endtask

   task automatic exception_rsp(input logic [7:0] fn, input logic [7:0] code,
                                input logic [3:0] st);
      tx_buf[0] = station;
      tx_buf[1] = fn | FN_EXC_FLAG;
      tx_buf[2] = code;
      emit_frame(3, st);
   endtask

   task automatic serve_frame();
      logic [7:0] fn;
      int unsigned addr, cnt;
      fn = rx_at(1);
      addr = {rx_at(2), rx_at(3)};
      cnt = {rx_at(4), rx_at(5)};
      if (fn == FN_RD_HOLD || fn == FN_RD_INPUT) begin
         if (addr + cnt > REG_COUNT_DEF) begin
            exception_rsp(fn, EXC_ADDR, ST_EXC_ADDR);
         end else if (cnt * 2 + 5 > TX_DEPTH_DEF) begin
            exception_rsp(fn, EXC_DEV, ST_EXC_DEV);
         end else begin
            tx_buf[0] = station;
            tx_buf[1] = fn;
            tx_buf[2] = 8'(cnt * 2);
            for (int unsigned i = 0; i < cnt; i++) begin
               tx_buf[3 + 2 * i] = regs[addr + i][15:8];
               tx_buf[4 + 2 * i] = regs[addr + i][7:0];
            end
            emit_frame(3 + cnt * 2, ST_RESPONSE);
         end
      end else if (fn == FN_WR_ONE || fn == FN_WR_MANY) begin
         if (addr > REG_COUNT_DEF) begin
            exception_rsp(fn, EXC_ADDR, ST_EXC_ADDR);
         end else begin
            tx_buf[0] = station;
            tx_buf[1] = fn;
            for (int unsigned i = 0; i < 4; i++) tx_buf[2 + i] = rx_at(2 + i);
            emit_frame(6, ST_RESPONSE);
            if (fn == FN_WR_ONE) begin
               if (addr < REG_COUNT_DEF) regs[addr] = 16'(cnt);
            end else begin
               for (int unsigned i = 0; i < cnt && addr + i < REG_COUNT_DEF; i++) begin
                  regs[addr + i] = {rx_at(7 + 2 * i), rx_at(8 + 2 * i)};
               end
            end
         end
      end else begin
         exception_rsp(fn, EXC_FUNC, ST_EXC_FUNC);
      end
   endtask

   task automatic on_timeout();
      if (mode != RX_RECV) begin
         push_status(ST_IDLE, 16'h0);
      end else if (rx_len < 3 || rx_len > RX_DEPTH_DEF) begin
         push_status(ST_TOO_SHORT, 16'h0);
      end else if (crc16_of(1'b1, rx_len - 2) != {rx_mem[rx_len - 1], rx_mem[rx_len - 2]}) begin
         push_status(ST_BAD_CRC, 16'h0);
      end else begin
         serve_frame();
         frames_served++;
      end
      mode = RX_WAIT;
      rx_len = 0;
   endtask

   task automatic on_byte(input logic [7:0] d);
      if (mode == RX_WAIT) begin
         if (d != station) begin
            mode = RX_SKIP;
            push_status(ST_OTHER, 16'h0);
            return;
         end
         mode = RX_RECV;
         rx_len = 0;
      end
      if (mode != RX_RECV) begin
         push_status(ST_IGNORED, 16'h0);
      end else if (rx_len < RX_DEPTH_DEF) begin
         rx_mem[rx_len] = d;
         rx_len++;
         push_status(ST_STORED, 16'h0);
      end else begin
         mode = RX_SKIP;
         push_status(ST_TOO_LONG, 16'h0);
      end
   endtask

   task automatic predict_request();
      case (req.action)
         ACT_BYTE: begin
            on_byte(req.rx_byte);
         end
         ACT_TIMEOUT: begin
            on_timeout();
         end
         ACT_HOST_WR: begin
            if (req.host_addr < REG_COUNT_DEF) regs[req.host_addr] = req.host_data;
            push_status(ST_HOST, 16'h0);
         end
         default: begin
            push_status(ST_HOST, req.host_addr < REG_COUNT_DEF ? regs[req.host_addr] : 16'h0);
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %h actual %h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_response();
      rsp_word_t w;
      if (expected_rsps.size() == 0) begin
         $error("response with nothing expected: tx_data %h status %0d", rsp.tx_data, rsp.status);
         fail_count++;
         return;
      end
      w = expected_rsps.pop_front();
      check_field("tx_data", w.tx_data, rsp.tx_data);
      check_field("tx_count", w.tx_count, rsp.tx_count);
      check_field("tx_last", w.tx_last, rsp.tx_last);
      check_field("status", w.status, rsp.status);
      check_field("host_read_data", w.host_read_data, rsp.host_read_data);
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      frames_served = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_rsps.delete();
         station = 8'h00;
         mode = RX_WAIT;
         rx_len = 0;
         foreach (rx_mem[i]) rx_mem[i] = 8'h00;
         foreach (regs[i]) regs[i] = 16'h0000;
         foreach (tx_buf[i]) tx_buf[i] = 8'h00;
      end else begin
         if (csr_wr_en) station = csr_wr_data;
         if (req.valid && req.ready) predict_request();
         if (rsp.valid && rsp.ready) compare_response();
      end
      pending = expected_rsps.size();
   end
endmodule

// ===== dv/tb_top.sv =====
// Top of the Modbus RTU slave engine testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
   import mbrs_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 700;
   localparam int PHASE_ITEMS = 25;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   mbrs_req_if req ();
   mbrs_rsp_if rsp ();

   int   fail_count, pending, frames_served;
   int   send_idle, recv_idle;
   int   hold_left;
   bit   hold_start;
   int   n_items;
   int   quiet;
   logic [7:0] station;
   logic [7:0] frame_q[$];

   modbus_rtu_slave_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req),
      .rsp_chan   (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   mbrs_checker i_chk (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .frames_served(frames_served)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random back-pressure, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left--;
      end else if (hold_start) begin
         hold_start = 1'b0;
         hold_left = 400;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("[modbus_rtu_slave_engine] ERROR");
            $finish;
         end
      end
   end

   function automatic logic [15:0] frame_crc();
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (frame_q[i]) begin
         c ^= {8'h00, frame_q[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   task automatic send(input logic [1:0] act, input logic [7:0] d,
                       input logic [15:0] ha, input logic [15:0] hd);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.action <= act;
      req.rx_byte <= d;
      req.host_addr <= ha;
      req.host_data <= hd;
      do @(posedge clock); while (!req.ready);
      n_items++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] d);
      send(ACT_BYTE, d, 16'($urandom), 16'($urandom));
   endtask

   task automatic send_timeout();
      send(ACT_TIMEOUT, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Send the queued frame with its CRC (optionally spoilt), then the silence
   task automatic send_frame(input bit spoil);
      logic [15:0] c;
      c = frame_crc() ^ (spoil ? 16'(1 << $urandom_range(15)) : 16'h0);
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
      foreach (frame_q[i]) send_byte(frame_q[i]);
      send_timeout();
   endtask

   task automatic start_frame(input logic [7:0] fn, input logic [15:0] addr,
                              input logic [15:0] cnt);
      frame_q = '{station, fn, addr[15:8], addr[7:0], cnt[15:8], cnt[7:0]};
   endtask

   task automatic write_many(input logic [15:0] addr, input logic [15:0] cnt,
                             input int words, input bit spoil);
      start_frame(FN_WR_MANY, addr, cnt);
      frame_q.push_back(8'(cnt * 2));
      repeat (words) begin
         frame_q.push_back(8'($urandom));
         frame_q.push_back(8'($urandom));
      end
      send_frame(spoil);
   endtask

   task automatic set_station(input logic [7:0] v);
      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      station = v;
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_step();
      int r;
      logic [15:0] cnt;
      r = $urandom_range(99);
      if (r < 45) begin
         cnt = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 70)) : 16'($urandom_range(0, 8));
         if ($urandom_range(19) == 0) cnt = 16'($urandom);
         start_frame($urandom_range(1) ? FN_RD_HOLD : FN_RD_INPUT,
                     ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70)), cnt);
         send_frame(1'b0);
      end else if (r < 58) begin
         start_frame(FN_WR_ONE, 16'($urandom_range(0, 66)), 16'($urandom));
         send_frame(1'b0);
      end else if (r < 72) begin
         cnt = ($urandom_range(14) == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom_range(0, 8));
         write_many(($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 66)),
                    cnt, ($urandom_range(4) == 0) ? $urandom_range(0, cnt) : cnt, 1'b0);
      end else if (r < 76) begin
         do r = $urandom_range(255);
         while (r == FN_RD_HOLD || r == FN_RD_INPUT || r == FN_WR_ONE || r == FN_WR_MANY);
         start_frame(8'(r), 16'($urandom), 16'($urandom));
         send_frame(1'b0);
      end else if (r < 80) begin
         start_frame(8'($urandom_range(1, 16)), 16'($urandom_range(0, 63)), 16'($urandom));
         send_frame(1'b1);
      end else if (r < 83) begin
         send_byte(station);
         repeat ($urandom_range(0, 1)) send_byte(8'($urandom));
         send_timeout();
      end else if (r < 87) begin
         send_byte(station ^ 8'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
         send_timeout();
      end else if (r < 90) begin
         send_timeout();
      end else begin
         send($urandom_range(1) ? ACT_HOST_WR : ACT_HOST_RD, 8'($urandom),
              ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63)),
              16'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      req.valid = 1'b0;
      req.action = ACT_BYTE;
      req.rx_byte = 8'h00;
      req.host_addr = 16'h0;
      req.host_data = 16'h0;
      rsp.ready = 1'b0;
      hold_left = 0;
      hold_start = 1'b0;
      n_items = 0;
      quiet = 0;
      station = 8'h00;
      send_idle = 22;
      recv_idle = 57;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: station 0 straight out of reset
      send_timeout();
      send(ACT_HOST_WR, 8'hFF, 16'd0, 16'hFFFF);
      send(ACT_HOST_WR, 8'h00, 16'd63, 16'hA5C3);
      send(ACT_HOST_WR, 8'h00, 16'hFFFF, 16'h1234);
      send(ACT_HOST_RD, 8'hFF, 16'd63, 16'h0);
      send(ACT_HOST_RD, 8'h00, 16'hFFFF, 16'hFFFF);
      start_frame(FN_RD_HOLD, 16'd0, 16'd64);
      send_frame(1'b0);
      start_frame(FN_RD_INPUT, 16'd63, 16'd2);
      send_frame(1'b0);
      start_frame(FN_RD_HOLD, 16'd5, 16'd0);
      send_frame(1'b0);
      start_frame(FN_WR_ONE, 16'd64, 16'hBEEF);
      send_frame(1'b0);
      start_frame(FN_WR_ONE, 16'd65, 16'hBEEF);
      send_frame(1'b0);
      write_many(16'd60, 16'd8, 8, 1'b0);
      write_many(16'd2, 16'd4, 1, 1'b0);
      start_frame(FN_RD_HOLD, 16'd0, 16'd64);
      send_frame(1'b0);
      start_frame(8'hFF, 16'd0, 16'd0);
      send_frame(1'b0);
      start_frame(FN_RD_HOLD, 16'd0, 16'd1);
      send_frame(1'b1);
      send_byte(8'h00);
      send_byte(8'h03);
      send_timeout();
      send_byte(8'h77);
      send_byte(8'h00);
      send_timeout();
      // Over-long frame: overflow, then skip the rest
      repeat (262) send_byte(8'h00);
      send_timeout();

      set_station(8'hFF);
      while (n_items < 390 + PHASE_ITEMS) random_step();
      send_idle = 57;
      recv_idle = 22;
      set_station(8'($urandom_range(1, 254)));
      while (n_items < 390 + 2 * PHASE_ITEMS) random_step();
      send_idle = 0;
      recv_idle = 0;
      set_station(8'($urandom));
      // Hold the responses off while requests keep coming
      hold_start = 1'b1;
      start_frame(FN_RD_HOLD, 16'd0, 16'd64);
      send_frame(1'b0);
      repeat (3) random_step();
      while (n_items < 390 + 3 * PHASE_ITEMS) random_step();

      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests over three flow-control phases and four station addresses;",
               n_items);
      $display("%0d frames passed the CRC check and were served.", frames_served);
      if (fail_count == 0 && pending == 0) begin
         $display("[modbus_rtu_slave_engine] OK");
      end else begin
         $display("[modbus_rtu_slave_engine] ERROR");
      end
      $finish;
   end
endmodule
